// ===== src/brb_pkg.sv =====
// Shared types, constants and helpers of the byte ring buffer.
`timescale 1ns / 1ps
`default_nettype none
package brb_pkg;

	localparam int DEPTH    = 256;
	localparam int MAX_READ = 64;
	localparam int PTR_W    = $clog2(DEPTH);
	localparam int SIZE_W   = $clog2(DEPTH + 1);
	localparam int CNT_W    = $clog2(MAX_READ + 1);
	localparam int LEN_W    = 8;
	localparam int BYTE_W   = 8;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
	localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(DEPTH);
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

	// Input op codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_WR_OK   = 2'd0;
	localparam logic [1:0] KIND_WR_REJ  = 2'd1;
	localparam logic [1:0] KIND_RD_BYTE = 2'd2;
	localparam logic [1:0] KIND_RD_NONE = 2'd3;

	// Register indexes
	localparam logic REG_RING_SIZE = 1'b0;

	// Command from front to back
	typedef struct packed {
		logic [1:0]        kind;
		logic              store;
		logic [PTR_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
		logic [CNT_W-1:0]  cnt;
	} cmd_t;

	function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p,
		input logic [SIZE_W-1:0] size);
		logic [SIZE_W:0] inc;
		begin
			inc = {1'b0, {(SIZE_W-PTR_W){1'b0}}, p} + (SIZE_W+1)'(1);
			next_pos = (inc >= {1'b0, size}) ? '0 : inc[PTR_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== src/brb_queue.sv =====
// Short command queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module brb_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire brb_pkg::cmd_t cmd_in,
	output logic               full,
	output logic               valid,
	output brb_pkg::cmd_t      cmd_out,
	input  wire logic          pop
);

	brb_pkg::cmd_t                   entry_q [brb_pkg::QDEPTH];
	logic [brb_pkg::QPTR_W-1:0]      wr_q;
	logic [brb_pkg::QPTR_W-1:0]      rd_q;
	logic [brb_pkg::QCNT_W-1:0]      cnt_q;

	assign full    = (cnt_q == brb_pkg::QCNT_W'(brb_pkg::QDEPTH));
	assign valid   = (cnt_q != '0);
	assign cmd_out = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + brb_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + brb_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + brb_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - brb_pkg::QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/brb_front.sv =====
// Front end: accepts requests, tracks pointers and chunk state, issues commands.
`timescale 1ns / 1ps
`default_nettype none
module brb_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          clear,
	input  wire logic [brb_pkg::SIZE_W-1:0]    size,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          op,
	input  wire logic                          first,
	input  wire logic [brb_pkg::LEN_W-1:0]     length,
	input  wire logic [brb_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic                          q_full,
	output logic                               push,
	output brb_pkg::cmd_t                      cmd
);

	logic [brb_pkg::PTR_W-1:0] rd_ptr_q, wr_ptr_q, fill_q;
	logic [brb_pkg::LEN_W-1:0] rem_q;
	logic                      rej_q;

	logic [brb_pkg::PTR_W-1:0] rd_ptr_d, wr_ptr_d, fill_d, stage_at, stage_next;
	logic [brb_pkg::LEN_W-1:0] rem_d;
	logic                      rej_d;
	logic [brb_pkg::SIZE_W-1:0] occ, free_sp, len_ext, want, n;
	logic [brb_pkg::SIZE_W:0]   rd_sum;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign len_ext  = {{(brb_pkg::SIZE_W-brb_pkg::LEN_W){1'b0}}, length};

	always_comb begin
		occ = (wr_ptr_q >= rd_ptr_q)
			? {{(brb_pkg::SIZE_W-brb_pkg::PTR_W){1'b0}}, wr_ptr_q - rd_ptr_q}
			: size - {1'b0, rd_ptr_q} + {1'b0, wr_ptr_q};
		free_sp = size - brb_pkg::SIZE_W'(1) - occ;
		want = (len_ext > brb_pkg::SIZE_W'(brb_pkg::MAX_READ))
			? brb_pkg::SIZE_W'(brb_pkg::MAX_READ) : len_ext;
		n = (want > occ) ? occ : want;
		rd_sum = {1'b0, {(brb_pkg::SIZE_W-brb_pkg::PTR_W){1'b0}}, rd_ptr_q}
			+ {1'b0, n};
		stage_at   = first ? wr_ptr_q : fill_q;
		stage_next = brb_pkg::next_pos(stage_at, size);

		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		fill_d   = fill_q;
		rem_d    = rem_q;
		rej_d    = rej_q;

		cmd.kind  = brb_pkg::KIND_WR_REJ;
		cmd.store = 1'b0;
		cmd.addr  = stage_at;
		cmd.data  = data_byte;
		cmd.cnt   = '0;

		if (op == brb_pkg::OP_READ) begin
			cmd.addr = rd_ptr_q;
			cmd.cnt  = n[brb_pkg::CNT_W-1:0];
			if (n == '0) begin
				cmd.kind = brb_pkg::KIND_RD_NONE;
			end else begin
				cmd.kind = brb_pkg::KIND_RD_BYTE;
				rd_ptr_d = (rd_sum >= {1'b0, size})
					? rd_sum[brb_pkg::PTR_W-1:0] - size[brb_pkg::PTR_W-1:0]
					: rd_sum[brb_pkg::PTR_W-1:0];
			end
		end else if (first) begin
			fill_d = wr_ptr_q;
			rem_d  = '0;
			rej_d  = 1'b0;
			if (len_ext > free_sp) begin
				// Drop the whole chunk
				rej_d = 1'b1;
				rem_d = length - brb_pkg::LEN_W'(1);
			end else begin
				cmd.kind = brb_pkg::KIND_WR_OK;
				if (length != '0) begin
					cmd.store = 1'b1;
					fill_d    = stage_next;
					rem_d     = length - brb_pkg::LEN_W'(1);
					if (length == brb_pkg::LEN_W'(1)) begin
						wr_ptr_d = stage_next;
					end
				end
			end
		end else if (rem_q == '0) begin
			cmd.kind = brb_pkg::KIND_WR_REJ;
		end else if (rej_q) begin
			rem_d = rem_q - brb_pkg::LEN_W'(1);
			if (rem_q == brb_pkg::LEN_W'(1)) begin
				rej_d = 1'b0;
			end
		end else begin
			cmd.kind  = brb_pkg::KIND_WR_OK;
			cmd.store = 1'b1;
			fill_d    = stage_next;
			rem_d     = rem_q - brb_pkg::LEN_W'(1);
			// Commit the chunk on its final byte
			if (rem_q == brb_pkg::LEN_W'(1)) begin
				wr_ptr_d = stage_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
			rem_q    <= '0;
			rej_q    <= 1'b0;
		end else if (clear) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
			rem_q    <= '0;
			rej_q    <= 1'b0;
		end else if (push) begin
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
			fill_q   <= fill_d;
			rem_q    <= rem_d;
			rej_q    <= rej_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/brb_back.sv =====
// Back end: ring memory, read runs and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none
module brb_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [brb_pkg::SIZE_W-1:0]  size,
	input  wire logic                        q_valid,
	input  wire brb_pkg::cmd_t               q_cmd,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       kind,
	output logic [brb_pkg::BYTE_W-1:0]       data_out,
	output logic                             last
);

	logic [brb_pkg::BYTE_W-1:0] mem [brb_pkg::DEPTH];
	logic [brb_pkg::BYTE_W-1:0] rdata_q;
	logic                       out_valid_q, last_q;
	logic [1:0]                 kind_q;
	logic                       run_q;
	logic [brb_pkg::PTR_W-1:0]  run_addr_q;
	logic [brb_pkg::CNT_W-1:0]  run_left_q;

	logic                       out_free, beat, rd_en, wr_en, beat_last;
	logic [1:0]                 beat_kind;
	logic [brb_pkg::PTR_W-1:0]  rd_addr;

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		beat     = out_free && (run_q || q_valid);
		q_pop    = out_free && !run_q && q_valid;
		if (run_q) begin
			beat_kind = brb_pkg::KIND_RD_BYTE;
			rd_addr   = run_addr_q;
			beat_last = (run_left_q == brb_pkg::CNT_W'(1));
		end else begin
			beat_kind = q_cmd.kind;
			rd_addr   = q_cmd.addr;
			beat_last = (q_cmd.kind != brb_pkg::KIND_RD_BYTE)
				|| (q_cmd.cnt == brb_pkg::CNT_W'(1));
		end
		rd_en = beat && (beat_kind == brb_pkg::KIND_RD_BYTE);
		wr_en = q_pop && q_cmd.store;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[q_cmd.addr] <= q_cmd.data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			kind_q      <= brb_pkg::KIND_WR_OK;
			last_q      <= 1'b0;
			run_q       <= 1'b0;
			run_addr_q  <= '0;
			run_left_q  <= '0;
		end else begin
			if (beat) begin
				out_valid_q <= 1'b1;
				kind_q      <= beat_kind;
				last_q      <= beat_last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (beat && run_q) begin
				run_addr_q <= brb_pkg::next_pos(run_addr_q, size);
				run_left_q <= run_left_q - brb_pkg::CNT_W'(1);
				if (run_left_q == brb_pkg::CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end else if (q_pop && (q_cmd.kind == brb_pkg::KIND_RD_BYTE)
				&& (q_cmd.cnt != brb_pkg::CNT_W'(1))) begin
				run_q      <= 1'b1;
				run_addr_q <= brb_pkg::next_pos(q_cmd.addr, size);
				run_left_q <= q_cmd.cnt - brb_pkg::CNT_W'(1);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign last      = last_q;
	assign data_out  = (kind_q == brb_pkg::KIND_RD_BYTE) ? rdata_q : '0;

endmodule
`default_nettype wire

// ===== src/byte_ring_buffer.sv =====
// Top level of the byte ring buffer: register port, front, queue and back.
`timescale 1ns / 1ps
`default_nettype none
// Byte ring buffer with one slot always left empty.
// Input channel (in_valid / in_stall): one request per byte of a write
// chunk (op 0, first marks the chunk head and carries its length), or a
// read request (op 1) asking for up to length bytes, at most 64.
// Output channel (out_valid / out_stall): one result per write byte
// (accepted or rejected), a run of read bytes with last on the final one,
// or a single read-empty result.
// A request taken into the command queue is popped by the back and its
// result registered. While out_stall is low, write bytes flow at one per
// cycle and a read run at one byte per cycle from the single read port.
// The front takes requests while the four-entry command queue has room,
// so it keeps accepting while a result waits on a stalled receiver.
// When out_stall is high the result register holds and the queue fills,
// after which in_stall rises.
// Reset empties the ring and sets ring_size to 256; writing ring_size over
// the register port also empties the ring. Ring memory contents are not
// cleared, and no read ever reaches an uncommitted slot.
module byte_ring_buffer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [brb_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [brb_pkg::PDATA_W-1:0]   pwdata,
	output logic [brb_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          op,
	input  wire logic                          first,
	input  wire logic [brb_pkg::LEN_W-1:0]     length,
	input  wire logic [brb_pkg::BYTE_W-1:0]    data_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         kind,
	output logic [brb_pkg::BYTE_W-1:0]         data_out,
	output logic                               last
);

	logic [brb_pkg::SIZE_W-1:0] ring_size_q;  // value as written
	logic [brb_pkg::SIZE_W-1:0] size_q;       // clamped size in use
	logic [brb_pkg::SIZE_W-1:0] wval;
	logic                       reg_hit, cfg_wr;
	logic                       q_push, q_full, q_valid, q_pop;
	brb_pkg::cmd_t              cmd_in, cmd_out;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[brb_pkg::PADDR_W-1] == brb_pkg::REG_RING_SIZE);
	assign cfg_wr  = psel && penable && pwrite && reg_hit;
	assign wval    = pwdata[brb_pkg::SIZE_W-1:0];
	assign prdata  = reg_hit
		? {{(brb_pkg::PDATA_W-brb_pkg::SIZE_W){1'b0}}, ring_size_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= brb_pkg::SIZE_RESET;
			size_q      <= brb_pkg::SIZE_RESET;
		end else if (cfg_wr) begin
			ring_size_q <= wval;
			// Clamp into the supported range
			if (wval < brb_pkg::SIZE_MIN) begin
				size_q <= brb_pkg::SIZE_MIN;
			end else if (wval > brb_pkg::SIZE_MAX) begin
				size_q <= brb_pkg::SIZE_MAX;
			end else begin
				size_q <= wval;
			end
		end
	end

	brb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cfg_wr),
		.size      (size_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.first     (first),
		.length    (length),
		.data_byte (data_byte),
		.q_full    (q_full),
		.push      (q_push),
		.cmd       (cmd_in)
	);

	brb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.cmd_in  (cmd_in),
		.full    (q_full),
		.valid   (q_valid),
		.cmd_out (cmd_out),
		.pop     (q_pop)
	);

	brb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.size      (size_q),
		.q_valid   (q_valid),
		.q_cmd     (cmd_out),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.data_out  (data_out),
		.last      (last)
	);

endmodule
`default_nettype wire

// ===== src/brb_checker.sv =====
// Port-level assertions for the byte ring buffer and their bind.
`timescale 1ns / 1ps
`default_nettype none
module brb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] kind,
	input wire logic [7:0] data_out,
	input wire logic       last
);

	// Write and empty-read results are single results
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != brb_pkg::KIND_RD_BYTE) |-> last)
		else $error("non-read result without last");

	// Only read bytes carry data
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != brb_pkg::KIND_RD_BYTE) |-> (data_out == '0))
		else $error("data on a non-read result");

	// A read run is not cut by another kind before its last byte
	a_run_whole: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && (kind == brb_pkg::KIND_RD_BYTE) && !last
		|=> !out_valid || (kind == brb_pkg::KIND_RD_BYTE))
		else $error("read run interrupted");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind)
		&& $stable(data_out) && $stable(last))
		else $error("stalled result changed");

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.kind      (kind),
	.data_out  (data_out),
	.last      (last)
);
`default_nettype wire

// ===== tb/byte_ring_buffer_test.sv =====
// Testbench of the byte ring buffer: random chunk and read traffic checked against a predictor.
`timescale 1ns / 1ps
module byte_ring_buffer_test;

	// Run length and pressure settings
	localparam int LIMIT_CYCLES = 500000;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_PCT     = 14;

	// One request on the input channel
	typedef struct {
		logic                       op;
		logic                       first;
		logic [brb_pkg::LEN_W-1:0]  len;
		logic [brb_pkg::BYTE_W-1:0] data;
	} request_t;

	// One result on the output channel
	typedef struct {
		logic [1:0]                 kind;
		logic [brb_pkg::BYTE_W-1:0] data;
		logic                       last;
	} result_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [brb_pkg::PADDR_W-1:0]   paddr = '0;
	logic [brb_pkg::PDATA_W-1:0]   pwdata = '0;
	logic [brb_pkg::PDATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          op = brb_pkg::OP_WRITE;
	logic                          first = 1'b0;
	logic [brb_pkg::LEN_W-1:0]     length = '0;
	logic [brb_pkg::BYTE_W-1:0]    data_byte = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [1:0]                    kind;
	logic [brb_pkg::BYTE_W-1:0]    data_out;
	logic                          last;

	request_t pending_requests[$];
	result_t  due_results[$];

	// Handshake and pacing state shared between the processes
	logic req_taken = 1'b0;
	logic calm = 1'b0;
	logic rx_hold_req = 1'b0;
	logic rx_hold_done = 1'b0;
	int   rx_hold_left = 0;
	int   errors = 0;
	int   cycle_count = 0;

	// Predicted ring state: memory, size in use, read and commit pointers,
	// staging pointer of the open chunk, bytes still due and the drop flag
	logic [brb_pkg::BYTE_W-1:0] ring_mem [brb_pkg::DEPTH];
	int unsigned                ring_slots;
	int unsigned                head;
	int unsigned                tail;
	int unsigned                fill_pos;
	int unsigned                chunk_left;
	logic                       chunk_drop;

	byte_ring_buffer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.first     (first),
		.length    (length),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.data_out  (data_out),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// Advance a ring position, wrapping at the size in use.
	function automatic int unsigned ring_next(input int unsigned p);
		return (p + 1 >= ring_slots) ? 0 : p + 1;
	endfunction

	// Count committed bytes waiting to be read.
	function automatic int unsigned ring_fill();
		return (tail >= head) ? tail - head : ring_slots - head + tail;
	endfunction

	task automatic expect_result(input logic [1:0] k, input logic [brb_pkg::BYTE_W-1:0] d,
		input logic l);
		result_t r;
		r.kind = k;
		r.data = d;
		r.last = l;
		due_results.push_back(r);
	endtask

	// Stage one byte of an open chunk; commit the chunk on its final byte.
	task automatic stage_byte(input logic [brb_pkg::BYTE_W-1:0] b);
		ring_mem[fill_pos] = b;
		fill_pos = ring_next(fill_pos);
		chunk_left = chunk_left - 1;
		if (chunk_left == 0)
			tail = fill_pos;
	endtask

	// Writing ring_size empties the ring; out-of-range sizes clamp.
	task automatic resize_ring(input logic [brb_pkg::PDATA_W-1:0] value);
		logic [brb_pkg::SIZE_W-1:0] v;
		v = value[brb_pkg::SIZE_W-1:0];
		if (v < brb_pkg::SIZE_MIN)
			ring_slots = brb_pkg::SIZE_MIN;
		else if (v > brb_pkg::SIZE_MAX)
			ring_slots = brb_pkg::SIZE_MAX;
		else
			ring_slots = v;
		head = 0;
		tail = 0;
		fill_pos = 0;
		chunk_left = 0;
		chunk_drop = 1'b0;
	endtask

	// Work out the results one accepted request causes and queue them.
	task automatic apply_request(input request_t r);
		int unsigned free_slots;
		int unsigned n;
		if (r.op == brb_pkg::OP_WRITE) begin
			if (r.first) begin
				// A chunk head abandons any open chunk and restarts staging.
				free_slots = ring_slots - 1 - ring_fill();
				fill_pos = tail;
				chunk_left = 0;
				chunk_drop = 1'b0;
				if (r.len > free_slots) begin
					chunk_drop = 1'b1;
					chunk_left = r.len - 1;
					expect_result(brb_pkg::KIND_WR_REJ, '0, 1'b1);
				end else begin
					// A zero-length head is accepted but stores nothing.
					if (r.len != 0) begin
						chunk_left = r.len;
						stage_byte(r.data);
					end
					expect_result(brb_pkg::KIND_WR_OK, '0, 1'b1);
				end
			end else if (chunk_left == 0) begin
				// Stray byte with no chunk open
				expect_result(brb_pkg::KIND_WR_REJ, '0, 1'b1);
			end else if (chunk_drop) begin
				chunk_left = chunk_left - 1;
				if (chunk_left == 0)
					chunk_drop = 1'b0;
				expect_result(brb_pkg::KIND_WR_REJ, '0, 1'b1);
			end else begin
				stage_byte(r.data);
				expect_result(brb_pkg::KIND_WR_OK, '0, 1'b1);
			end
		end else begin
			n = r.len;
			if (n > brb_pkg::MAX_READ)
				n = brb_pkg::MAX_READ;
			if (n > ring_fill())
				n = ring_fill();
			if (n == 0) begin
				expect_result(brb_pkg::KIND_RD_NONE, '0, 1'b1);
			end else begin
				for (int k = 0; k < n; k++) begin
					expect_result(brb_pkg::KIND_RD_BYTE, ring_mem[head], k == n - 1);
					head = ring_next(head);
				end
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Channel processes
	// ---------------------------------------------------------------

	// Sender: present the next pending request once the current one is taken.
	// Hold valid and payload steady while the block stalls.
	always @(negedge clk) begin : drive_requests
		request_t nxt;
		if (arst_n && (!in_valid || req_taken)) begin
			if (pending_requests.size() != 0 &&
				(calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				nxt = pending_requests.pop_front();
				in_valid  <= 1'b1;
				op        <= nxt.op;
				first     <= nxt.first;
				length    <= nxt.len;
				data_byte <= nxt.data;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here so the
	// command queue fills up and the block stalls its input.
	always @(negedge clk) begin : drive_stall
		if (rx_hold_left > 0) begin
			out_stall    <= 1'b1;
			rx_hold_left <= rx_hold_left - 1;
		end else if (rx_hold_req && !rx_hold_done) begin
			rx_hold_done <= 1'b1;
			rx_hold_left <= HOLD_CYCLES;
			out_stall    <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Monitor: predict on each accepted request, check each accepted result
	// against the oldest prediction.
	always @(posedge clk) begin : watch_channels
		request_t got_req;
		result_t  want;
		req_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			got_req.op    = op;
			got_req.first = first;
			got_req.len   = length;
			got_req.data  = data_byte;
			apply_request(got_req);
		end
		if (out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$error("result with nothing expected: kind %0d data_out %0h last %0b",
					kind, data_out, last);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					errors++;
				end
				if (data_out !== want.data) begin
					$error("data_out: expected %0h, got %0h", want.data, data_out);
					errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					errors++;
				end
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	task automatic queue_request(input logic o, input logic f, input int unsigned len,
		input int unsigned d);
		request_t r;
		r.op    = o;
		r.first = f;
		r.len   = len[brb_pkg::LEN_W-1:0];
		r.data  = d[brb_pkg::BYTE_W-1:0];
		pending_requests.push_back(r);
	endtask

	// Queue a chunk head declaring len bytes, then sent-1 body bytes.
	task automatic queue_chunk(input int unsigned len, input int unsigned sent);
		queue_request(brb_pkg::OP_WRITE, 1'b1, len, $urandom);
		for (int i = 1; i < sent; i++)
			queue_request(brb_pkg::OP_WRITE, 1'b0, $urandom, $urandom);
	endtask

	// Mostly well-formed chunks and reads with random content, the rest
	// truncated chunks and noise.
	task automatic queue_traffic(input int count, input int unsigned slots);
		int          queued;
		int unsigned pick;
		int unsigned sel;
		int unsigned len;
		int unsigned sent;
		int unsigned cap;
		queued = 0;
		cap = (slots > 48) ? 48 : slots;
		while (queued < count) begin
			pick = $urandom_range(0, 99);
			sel  = $urandom_range(0, 99);
			if (pick < 45) begin
				if (sel < 65)
					len = $urandom_range(1, 8);
				else if (sel < 85)
					len = $urandom_range(1, cap);
				else if (sel < 95)
					len = 0;
				else
					len = $urandom_range(0, 255);
				// Long heads send at most cap bytes; the rest of the body is cut off.
				sent = (len == 0) ? 1 : ((len > cap) ? cap : len);
				queue_chunk(len, sent);
			end else if (pick < 80) begin
				if (sel < 50)
					len = $urandom_range(1, 16);
				else if (sel < 75)
					len = $urandom_range(17, 255);
				else if (sel < 85)
					len = 0;
				else
					len = $urandom_range(64, 255);
				sent = 1;
				queue_request(brb_pkg::OP_READ, 1'($urandom), len, $urandom);
			end else if (pick < 90) begin
				// Drop the tail of a chunk; the next head interrupts it.
				len  = $urandom_range(2, 16);
				sent = $urandom_range(1, len - 1);
				queue_chunk(len, sent);
			end else begin
				sent = 1;
				queue_request(1'($urandom), 1'($urandom), $urandom, $urandom);
			end
			queued += sent;
		end
	endtask

	// Hold until no request is waiting or in flight and every result is back.
	// Look at the rising edge, where the sender's last update has settled.
	task automatic wait_drained();
		@(posedge clk);
		while (pending_requests.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_ring_size(input logic [brb_pkg::PDATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = brb_pkg::PADDR_W'(4 * brb_pkg::REG_RING_SIZE);
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		resize_ring(value);
	endtask

	// Change the size while idle, then run a stretch of traffic.
	task automatic run_phase(input logic [brb_pkg::PDATA_W-1:0] value, input int count);
		wait_drained();
		write_ring_size(value);
		queue_traffic(count, ring_slots);
	endtask

	initial begin
		resize_ring(brb_pkg::PDATA_W'(brb_pkg::SIZE_RESET));
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset size
		queue_request(brb_pkg::OP_READ, 1'b1, 0, 8'hFF);     // empty read, zero length
		queue_request(brb_pkg::OP_READ, 1'b0, 5, 8'h00);     // empty read, nothing stored
		queue_request(brb_pkg::OP_WRITE, 1'b0, 0, 8'hFF);    // stray byte
		queue_request(brb_pkg::OP_WRITE, 1'b1, 0, 8'hFF);    // zero-length chunk
		queue_request(brb_pkg::OP_WRITE, 1'b1, 3, 8'h00);
		queue_request(brb_pkg::OP_WRITE, 1'b0, 255, 8'hFF);
		queue_request(brb_pkg::OP_WRITE, 1'b0, 0, 8'h5A);
		queue_request(brb_pkg::OP_READ, 1'b1, 255, 8'hFF);   // clamp to what is stored
		queue_request(brb_pkg::OP_WRITE, 1'b1, 4, 8'h11);    // chunk cut short ...
		queue_request(brb_pkg::OP_WRITE, 1'b0, 4, 8'h22);
		queue_request(brb_pkg::OP_WRITE, 1'b1, 2, 8'h33);    // ... by a new head
		queue_request(brb_pkg::OP_WRITE, 1'b0, 0, 8'h44);
		queue_request(brb_pkg::OP_READ, 1'b0, 1, 8'h00);
		queue_request(brb_pkg::OP_WRITE, 1'b1, 255, 8'hEE);  // does not fit: rejected
		queue_request(brb_pkg::OP_WRITE, 1'b0, 7, 8'hDD);    // dropped with its chunk
		queue_request(brb_pkg::OP_WRITE, 1'b1, 1, 8'h77);    // head during a rejected chunk
		queue_request(brb_pkg::OP_READ, 1'b1, 0, 8'hFF);     // zero length with data stored
		queue_request(brb_pkg::OP_READ, 1'b0, 64, 8'h00);
		queue_request(brb_pkg::OP_WRITE, 1'b0, 1, 8'h01);    // stray byte

		// Full size with one long receiver hold-off to back the block up
		wait_drained();
		write_ring_size(brb_pkg::PDATA_W'(256));
		rx_hold_req = 1'b1;
		queue_traffic(70, ring_slots);

		run_phase(brb_pkg::PDATA_W'(2), 25);                 // smallest ring
		run_phase(32'hFFFF_FE01, 15);                        // masks to 1, acts as 2

		// Above the depth, with no idling on either side
		wait_drained();
		write_ring_size(brb_pkg::PDATA_W'(511));
		calm = 1'b1;
		queue_traffic(60, ring_slots);
		wait_drained();
		calm = 1'b0;

		run_phase(brb_pkg::PDATA_W'(0), 10);
		run_phase(brb_pkg::PDATA_W'($urandom_range(3, 40)), 40);
		run_phase(brb_pkg::PDATA_W'(255), 40);

		wait_drained();
		repeat (16) @(negedge clk);
		if (errors == 0 && due_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
